>>> hdl/vtt_pkg.sv
// shared types, codes and the cell width table of the escape sequence tokenizer
package vtt_pkg;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_CTRL = 2'd1;
	localparam logic [1:0] KIND_ESC  = 2'd2;
	localparam logic [1:0] KIND_CSI  = 2'd3;

	// private marker codes
	localparam logic [2:0] PRIV_NONE = 3'd0;
	localparam logic [2:0] PRIV_QM   = 3'd1;
	localparam logic [2:0] PRIV_GT   = 3'd2;
	localparam logic [2:0] PRIV_EQ   = 3'd3;
	localparam logic [2:0] PRIV_LT   = 3'd4;

	// special bytes and values
	localparam logic [7:0]  BYTE_ESC     = 8'h1b;
	localparam logic [7:0]  BYTE_DEL     = 8'h7f;
	localparam logic [7:0]  BYTE_BEL     = 8'h07;
	localparam logic [20:0] CP_REPLACE   = 21'h00fffd;
	localparam logic [15:0] PARAM_SAT    = 16'hffff;

	// escape parser modes
	typedef enum logic [7:0] {
		PM_GROUND  = 8'b0000_0001,
		PM_ESC     = 8'b0000_0010,
		PM_CSI     = 8'b0000_0100,
		PM_OSC     = 8'b0000_1000,
		PM_OSC_ESC = 8'b0001_0000,
		PM_CHARSET = 8'b0010_0000,
		PM_DCS     = 8'b0100_0000,
		PM_DCS_ESC = 8'b1000_0000
	} pmode_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_direct;
		logic rd;
		logic put;
	} vtt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic one_result;
		logic csi_multi;
		logic emit_last;
	} vtt_status_t;

	// terminal cell width of a code point
	function automatic logic [1:0] width_of(input logic [20:0] c);
		logic [1:0] w;
		w = 2'd1;
		if (c < 21'h300) begin
			w = 2'd1;
		end else if ((c <= 21'h36f) || (c >= 21'h200b && c <= 21'h200f) ||
				(c >= 21'hfe00 && c <= 21'hfe0f)) begin
			w = 2'd0;
		end else if ((c >= 21'h1100 && c <= 21'h115f) || (c >= 21'h2e80 && c <= 21'h303e) ||
				(c >= 21'h3041 && c <= 21'h33ff) || (c >= 21'h3400 && c <= 21'h4dbf) ||
				(c >= 21'h4e00 && c <= 21'h9fff) || (c >= 21'ha000 && c <= 21'ha4cf) ||
				(c >= 21'hac00 && c <= 21'hd7a3) || (c >= 21'hf900 && c <= 21'hfaff) ||
				(c >= 21'hfe30 && c <= 21'hfe4f) || (c >= 21'hff00 && c <= 21'hff60) ||
				(c >= 21'hffe0 && c <= 21'hffe6) || (c >= 21'h1f300 && c <= 21'h1f64f) ||
				(c >= 21'h1f900 && c <= 21'h1f9ff) ||
				(c >= 21'h20000 && c <= 21'h3fffd)) begin
			w = 2'd2;
		end
		return w;
	endfunction

	// private marker code of a byte, none if not a marker
	function automatic logic [2:0] marker_code(input logic [7:0] b);
		logic [2:0] m;
		case (b)
			8'h3f: m = PRIV_QM;
			8'h3e: m = PRIV_GT;
			8'h3d: m = PRIV_EQ;
			8'h3c: m = PRIV_LT;
			default: m = PRIV_NONE;
		endcase
		return m;
	endfunction

endpackage

>>> hdl/vtt_ctrl.sv
// controller of the escape sequence tokenizer: input accept and csi parameter emission
module vtt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  vtt_pkg::vtt_status_t status,
	output vtt_pkg::vtt_cmd_t   cmd
);
	import vtt_pkg::*;

	typedef enum logic [2:0] {
		ST_ACCEPT = 3'b001,
		ST_READ   = 3'b010,
		ST_PUT    = 3'b100
	} cstate_t;

	cstate_t state_q, state_n;
	logic    out_valid_q;
	logic    out_free;
	logic    load;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode and next state
	always_comb begin
		state_n          = state_q;
		in_ready         = 1'b0;
		cmd              = '0;
		case (state_q)
			ST_ACCEPT: begin
				in_ready         = out_free;
				cmd.accept       = in_valid && out_free;
				cmd.load_direct  = cmd.accept && status.one_result;
				if (cmd.accept && status.csi_multi) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_n = ST_PUT;
			end
			ST_PUT: begin
				cmd.put = out_free;
				if (out_free) begin
					state_n = status.emit_last ? ST_ACCEPT : ST_READ;
				end
			end
			default: state_n = ST_ACCEPT;
		endcase
	end

	assign load = cmd.load_direct || cmd.put;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

>>> hdl/vtt_datapath.sv
// datapath of the escape sequence tokenizer: parser state, utf-8 decode, parameters, result register
module vtt_datapath #(
	parameter int MAX_PARAMS     = 32,
	parameter int SEQUENCE_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  vtt_pkg::vtt_cmd_t    cmd,
	output vtt_pkg::vtt_status_t status,
	output logic [1:0]           kind,
	output logic [20:0]          code_point,
	output logic [1:0]           cell_width,
	output logic [7:0]           char_code,
	output logic [2:0]           private_marker,
	output logic [5:0]           intermediate,
	output logic [4:0]           param_index,
	output logic [15:0]          param_value,
	output logic [5:0]           param_count,
	output logic                 last
);
	import vtt_pkg::*;

	localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam int SW = $clog2(SEQUENCE_BYTES + 1);

	// parser state
	pmode_t          mode_q, mode_n;
	logic [20:0]     acc_q, acc_n;
	logic [1:0]      rem_q, rem_n;
	logic [SW-1:0]   seq_q, seq_n;
	logic [2:0]      priv_q, priv_n;
	logic [5:0]      inter_q, inter_n;
	logic [IW-1:0]   idx_q, idx_n;
	logic [15:0]     cur_q, cur_n;
	logic            dig_q, dig_n;
	logic [7:0]      lsb_q, lsb_n;
	logic [CW-1:0]   cnt_q, cnt_n;
	logic [CW-1:0]   k_q;
	logic [15:0]     rdata_q;

	// closed parameters, one write port and one registered read port
	logic [15:0]     param_mem [MAX_PARAMS];
	logic            mem_we;

	// direct single result
	logic [1:0]      d_kind;
	logic [20:0]     d_cp;
	logic [7:0]      d_code;
	logic            d_csi;
	logic            emit;
	logic            final_csi;
	logic [19:0]     prod;
	logic [7:0]      c;

	// output register
	logic [1:0]      kind_q;
	logic [20:0]     cp_q;
	logic [1:0]      width_q;
	logic [7:0]      code_q;
	logic [2:0]      priv_out_q;
	logic [5:0]      inter_out_q;
	logic [4:0]      pidx_q;
	logic [15:0]     pval_q;
	logic [5:0]      pcnt_q;
	logic            last_q;

	assign c = data_byte;

	// next parser state for the byte on the input
	always_comb begin
		mode_n    = mode_q;
		acc_n     = acc_q;
		rem_n     = rem_q;
		seq_n     = seq_q;
		priv_n    = priv_q;
		inter_n   = inter_q;
		idx_n     = idx_q;
		cur_n     = cur_q;
		dig_n     = dig_q;
		lsb_n     = lsb_q;
		mem_we    = 1'b0;
		emit      = 1'b0;
		d_kind    = KIND_CHAR;
		d_cp      = '0;
		d_code    = '0;
		d_csi     = 1'b0;
		final_csi = 1'b0;
		prod      = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1) + {16'b0, 4'(lsb_q - 8'h30)};
		case (mode_q)
			PM_GROUND: begin
				if (c == BYTE_ESC) begin
					mode_n = PM_ESC;
					rem_n  = '0;
				end else if (c < 8'h20) begin
					rem_n  = '0;
					emit   = 1'b1;
					d_kind = KIND_CTRL;
					d_code = c;
				end else if (c == BYTE_DEL) begin
					// ignored, decoder keeps its state
				end else if (rem_q != '0 && c[7:6] == 2'b10) begin
					acc_n = {acc_q[14:0], c[5:0]};
					rem_n = rem_q - 2'd1;
					if (rem_q == 2'd1) begin
						emit = 1'b1;
						d_cp = acc_n;
					end
				end else begin
					rem_n = '0;
					if (c < 8'h80) begin
						emit = 1'b1;
						d_cp = {13'b0, c};
					end else if (c[7:5] == 3'b110) begin
						acc_n = {16'b0, c[4:0]};
						rem_n = 2'd1;
					end else if (c[7:4] == 4'b1110) begin
						acc_n = {17'b0, c[3:0]};
						rem_n = 2'd2;
					end else if (c[7:3] == 5'b11110) begin
						acc_n = {18'b0, c[2:0]};
						rem_n = 2'd3;
					end else begin
						emit = 1'b1;
						d_cp = CP_REPLACE;
					end
				end
			end
			PM_ESC, PM_OSC_ESC: begin
				if (mode_q == PM_OSC_ESC && c == 8'h5c) begin
					mode_n = PM_GROUND;
				end else if (c == 8'h5b) begin
					mode_n  = PM_CSI;
					seq_n   = '0;
					priv_n  = PRIV_NONE;
					inter_n = '0;
					idx_n   = '0;
					cur_n   = '0;
					dig_n   = 1'b0;
					lsb_n   = '0;
				end else if (c == 8'h5d) begin
					mode_n = PM_OSC;
				end else if (c == 8'h50) begin
					mode_n = PM_DCS;
				end else if (c == 8'h28 || c == 8'h29 || c == 8'h2a || c == 8'h2b ||
						c == 8'h23 || c == 8'h25) begin
					mode_n = PM_CHARSET;
				end else begin
					mode_n = PM_GROUND;
					emit   = 1'b1;
					d_kind = KIND_ESC;
					d_code = c;
				end
			end
			PM_CHARSET: mode_n = PM_GROUND;
			PM_CSI: begin
				if (c == BYTE_ESC) begin
					mode_n = PM_ESC;
				end else if (c < 8'h20) begin
					emit   = 1'b1;
					d_kind = KIND_CTRL;
					d_code = c;
				end else begin
					if (seq_q < SW'(SEQUENCE_BYTES)) begin
						// previous stored byte is now parsed
						if (seq_q != '0) begin
							if (seq_q == SW'(1) && marker_code(lsb_q) != PRIV_NONE) begin
								priv_n = marker_code(lsb_q);
							end else if (lsb_q >= 8'h30 && lsb_q <= 8'h39) begin
								cur_n = (prod > 20'hffff) ? PARAM_SAT : prod[15:0];
								dig_n = 1'b1;
							end else if (lsb_q == 8'h3b || lsb_q == 8'h3a) begin
								if (CW'(idx_q) + CW'(1) < CW'(MAX_PARAMS)) begin
									mem_we = 1'b1;
									idx_n  = idx_q + IW'(1);
									cur_n  = '0;
								end
								dig_n = 1'b1;
							end else if (lsb_q >= 8'h20 && lsb_q <= 8'h2f) begin
								inter_n = lsb_q[5:0];
							end
						end
						lsb_n = c;
						seq_n = seq_q + SW'(1);
					end
					if (c >= 8'h40 && c <= 8'h7e) begin
						mode_n    = PM_GROUND;
						final_csi = 1'b1;
					end
				end
			end
			PM_OSC: begin
				if (c == BYTE_BEL) begin
					mode_n = PM_GROUND;
				end else if (c == BYTE_ESC) begin
					mode_n = PM_OSC_ESC;
				end
			end
			PM_DCS: begin
				if (c == BYTE_ESC) begin
					mode_n = PM_DCS_ESC;
				end
			end
			PM_DCS_ESC: mode_n = (c == 8'h5c) ? PM_GROUND : PM_DCS;
			default: mode_n = PM_GROUND;
		endcase
		cnt_n = dig_n ? (CW'(idx_n) + CW'(1)) : '0;
		if (final_csi && cnt_n == '0) begin
			emit   = 1'b1;
			d_csi  = 1'b1;
			d_kind = KIND_CSI;
			d_code = lsb_n;
		end
	end

	assign status.one_result = emit;
	assign status.csi_multi  = final_csi && (cnt_n != '0);
	assign status.emit_last  = (k_q + CW'(1)) == cnt_q;

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PM_GROUND;
			acc_q   <= '0;
			rem_q   <= '0;
			seq_q   <= '0;
			priv_q  <= '0;
			inter_q <= '0;
			idx_q   <= '0;
			cur_q   <= '0;
			dig_q   <= 1'b0;
			lsb_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.accept) begin
				mode_q  <= mode_n;
				acc_q   <= acc_n;
				rem_q   <= rem_n;
				seq_q   <= seq_n;
				priv_q  <= priv_n;
				inter_q <= inter_n;
				idx_q   <= idx_n;
				cur_q   <= cur_n;
				dig_q   <= dig_n;
				lsb_q   <= lsb_n;
				cnt_q   <= cnt_n;
				k_q     <= '0;
			end else if (cmd.put) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	// parameter memory, the open parameter is still in cur_q
	always_ff @(posedge clk) begin
		if (cmd.accept && mem_we) begin
			param_mem[idx_q] <= cur_q;
		end
		if (cmd.rd) begin
			rdata_q <= (k_q[IW-1:0] == idx_q) ? cur_q : param_mem[k_q[IW-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			kind_q      <= d_kind;
			cp_q        <= d_cp;
			width_q     <= (d_kind == KIND_CHAR) ? width_of(d_cp) : 2'd0;
			code_q      <= d_code;
			priv_out_q  <= d_csi ? priv_n : PRIV_NONE;
			inter_out_q <= d_csi ? inter_n : 6'd0;
			pidx_q      <= '0;
			pval_q      <= '0;
			pcnt_q      <= '0;
			last_q      <= 1'b1;
		end else if (cmd.put) begin
			kind_q      <= KIND_CSI;
			cp_q        <= '0;
			width_q     <= '0;
			code_q      <= lsb_q;
			priv_out_q  <= priv_q;
			inter_out_q <= inter_q;
			pidx_q      <= 5'(k_q);
			pval_q      <= rdata_q;
			pcnt_q      <= 6'(cnt_q);
			last_q      <= status.emit_last;
		end
	end

	assign kind           = kind_q;
	assign code_point     = cp_q;
	assign cell_width     = width_q;
	assign char_code      = code_q;
	assign private_marker = priv_out_q;
	assign intermediate   = inter_out_q;
	assign param_index    = pidx_q;
	assign param_value    = pval_q;
	assign param_count    = pcnt_q;
	assign last           = last_q;
endmodule

>>> hdl/vt_escape_sequence_tokenizer.sv
// top level of the vt escape sequence tokenizer
//
// Input channel in_valid/in_ready carries one byte of terminal output per
// transaction. Output channel out_valid/out_ready carries one token per
// transaction; last marks the final token caused by a byte.
// A byte is taken and its single token, if any, appears in the result
// register the next cycle; unstalled, plain text runs at one byte per cycle.
// The byte may be taken while the previous token is taken in the same cycle.
// A csi final byte with N parameters is followed by N parameter tokens,
// each a registered parameter memory read and then a result load,
// during which no byte is accepted; the byte after it is accepted once the
// last parameter token is loaded.
// When the receiver stalls, the token waits in the result register and no
// further byte is accepted until it leaves.
// Reset puts the parser in ground state with an empty utf-8 decoder and
// clears the output valid; no clearing pass is needed.
module vt_escape_sequence_tokenizer #(
	parameter int MAX_PARAMS     = 32,
	parameter int SEQUENCE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [20:0] code_point,
	output logic [1:0]  cell_width,
	output logic [7:0]  char_code,
	output logic [2:0]  private_marker,
	output logic [5:0]  intermediate,
	output logic [4:0]  param_index,
	output logic [15:0] param_value,
	output logic [5:0]  param_count,
	output logic        last
);
	import vtt_pkg::*;

	vtt_cmd_t    cmd;
	vtt_status_t status;

	// controller
	vtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	vtt_datapath #(
		.MAX_PARAMS     (MAX_PARAMS),
		.SEQUENCE_BYTES (SEQUENCE_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.cmd            (cmd),
		.status         (status),
		.kind           (kind),
		.code_point     (code_point),
		.cell_width     (cell_width),
		.char_code      (char_code),
		.private_marker (private_marker),
		.intermediate   (intermediate),
		.param_index    (param_index),
		.param_value    (param_value),
		.param_count    (param_count),
		.last           (last)
	);
endmodule
